// ===== rtl/pnj_pkg.sv =====
// Package for the point normalization Jacobian unit.
// Holds field widths, lane codes and pipeline sizes; no dependencies.
package pnj_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned NORM_W        = 31;
  localparam int unsigned PROD_W        = 2 * COORD_W;
  localparam int unsigned N2_W          = 2 * NORM_W;
  localparam int unsigned N3_W          = 3 * NORM_W;
  localparam int unsigned Q_W           = 32;
  localparam int unsigned QX_W          = Q_W + 1;
  localparam int unsigned DIV_STAGES    = QX_W;
  localparam int unsigned DIV_W         = 128;
  localparam int unsigned LANES         = 6;

  localparam int unsigned LANE_XX = 0;
  localparam int unsigned LANE_YY = 1;
  localparam int unsigned LANE_ZZ = 2;
  localparam int unsigned LANE_XY = 3;
  localparam int unsigned LANE_XZ = 4;
  localparam int unsigned LANE_YZ = 5;

  typedef logic [LANES-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [LANES-1:0][Q_W-1:0]    entry_vec_t;

endpackage

// ===== rtl/pnj_front.sv =====
// Front pipeline of the normalization Jacobian: magnitudes, products, n^3.
// Four register stages; uses pnj_pkg.
module pnj_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [pnj_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [pnj_pkg::COORD_W-1:0]  y_coord_i,
  input  logic signed [pnj_pkg::COORD_W-1:0]  z_coord_i,
  input  logic        [pnj_pkg::NORM_W-1:0]   norm_i,
  output logic                                valid_o,
  output pnj_pkg::prod_vec_t                  prod_o,
  output logic        [pnj_pkg::N3_W-1:0]     n3_o,
  output logic        [pnj_pkg::LANES-1:0]    neg_o,
  output logic                                zero_o
);

  localparam int unsigned CW = pnj_pkg::COORD_W;
  localparam int unsigned NW = pnj_pkg::NORM_W;
  localparam int unsigned PW = pnj_pkg::PROD_W;

  logic [3:0] v_q, v_d;

  logic [CW-1:0] ax_q, ay_q, az_q;
  logic          sx_q, sy_q, sz_q;
  logic [NW-1:0] n1_q;
  logic          z1_q;

  logic [PW-1:0]           x2_q, y2_q, z2_q, pxy_q, pxz_q, pyz_q;
  logic [pnj_pkg::N2_W-1:0] n2_q;
  logic [NW-1:0]           n2n_q;
  logic                    s2x_q, s2y_q, s2z_q, z2f_q;

  pnj_pkg::prod_vec_t      p3_q;
  logic [pnj_pkg::LANES-1:0] neg3_q;
  logic [2*NW-1:0]         lo3_q, hi3_q;
  logic                    z3_q;

  pnj_pkg::prod_vec_t      p4_q;
  logic [pnj_pkg::LANES-1:0] neg4_q;
  logic [pnj_pkg::N3_W-1:0] n3_q;
  logic                    z4_q;

  assign v_d = {v_q[2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= x_coord_i[CW-1] ? CW'(-x_coord_i) : x_coord_i;
      ay_q <= y_coord_i[CW-1] ? CW'(-y_coord_i) : y_coord_i;
      az_q <= z_coord_i[CW-1] ? CW'(-z_coord_i) : z_coord_i;
      sx_q <= x_coord_i[CW-1];
      sy_q <= y_coord_i[CW-1];
      sz_q <= z_coord_i[CW-1];
      n1_q <= norm_i;
      z1_q <= (norm_i == '0);

      x2_q  <= PW'(ax_q) * PW'(ax_q);
      y2_q  <= PW'(ay_q) * PW'(ay_q);
      z2_q  <= PW'(az_q) * PW'(az_q);
      pxy_q <= PW'(ax_q) * PW'(ay_q);
      pxz_q <= PW'(ax_q) * PW'(az_q);
      pyz_q <= PW'(ay_q) * PW'(az_q);
      n2_q  <= pnj_pkg::N2_W'(n1_q) * pnj_pkg::N2_W'(n1_q);
      n2n_q <= n1_q;
      s2x_q <= sx_q;
      s2y_q <= sy_q;
      s2z_q <= sz_q;
      z2f_q <= z1_q;

      p3_q[pnj_pkg::LANE_XX] <= y2_q + z2_q;
      p3_q[pnj_pkg::LANE_YY] <= x2_q + z2_q;
      p3_q[pnj_pkg::LANE_ZZ] <= x2_q + y2_q;
      p3_q[pnj_pkg::LANE_XY] <= pxy_q;
      p3_q[pnj_pkg::LANE_XZ] <= pxz_q;
      p3_q[pnj_pkg::LANE_YZ] <= pyz_q;
      neg3_q[pnj_pkg::LANE_XX] <= 1'b0;
      neg3_q[pnj_pkg::LANE_YY] <= 1'b0;
      neg3_q[pnj_pkg::LANE_ZZ] <= 1'b0;
      neg3_q[pnj_pkg::LANE_XY] <= (s2x_q == s2y_q) && (pxy_q != '0);
      neg3_q[pnj_pkg::LANE_XZ] <= (s2x_q == s2z_q) && (pxz_q != '0);
      neg3_q[pnj_pkg::LANE_YZ] <= (s2y_q == s2z_q) && (pyz_q != '0);
      lo3_q <= (2*NW)'(n2_q[NW-1:0]) * (2*NW)'(n2n_q);
      hi3_q <= (2*NW)'(n2_q[2*NW-1:NW]) * (2*NW)'(n2n_q);
      z3_q  <= z2f_q;

      p4_q   <= p3_q;
      neg4_q <= neg3_q;
      n3_q   <= (pnj_pkg::N3_W'(hi3_q) << NW) + pnj_pkg::N3_W'(lo3_q);
      z4_q   <= z3_q;
    end
  end

  assign valid_o = v_q[3];
  assign prod_o  = p4_q;
  assign n3_o    = n3_q;
  assign neg_o   = neg4_q;
  assign zero_o  = z4_q;

endmodule

// ===== rtl/pnj_div.sv =====
// Pipelined restoring divider for six lanes sharing divisor n^3, one
// quotient bit per stage, followed by saturation and the output register.
// Uses pnj_pkg.
module pnj_div #(
  parameter int unsigned FRAC_BITS = pnj_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  pnj_pkg::prod_vec_t                prod_i,
  input  logic [pnj_pkg::N3_W-1:0]          n3_i,
  input  logic [pnj_pkg::LANES-1:0]         neg_i,
  input  logic                              zero_i,
  output logic                              valid_o,
  output pnj_pkg::entry_vec_t               entry_o,
  output logic                              sat_o,
  output logic                              zero_o
);

  localparam int unsigned DW = pnj_pkg::DIV_W;
  localparam int unsigned NS = pnj_pkg::DIV_STAGES;
  localparam int unsigned L  = pnj_pkg::LANES;
  localparam int unsigned QW = pnj_pkg::Q_W;
  localparam int unsigned XW = pnj_pkg::QX_W;

  logic [NS:0]                    v_q;
  logic [L-1:0][DW-1:0]           rem_q  [NS+1];
  logic [L-1:0][XW-1:0]           quo_q  [NS+1];
  logic [pnj_pkg::N3_W-1:0]       n3_q   [NS+1];
  logic [L-1:0]                   neg_q  [NS+1];
  logic                           zero_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[NS-1:0], valid_i};
      valid_o <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < L; l++) begin
        rem_q[0][l] <= DW'(prod_i[l]) << (2 * FRAC_BITS);
        quo_q[0][l] <= '0;
      end
      n3_q[0]   <= n3_i;
      neg_q[0]  <= neg_i;
      zero_q[0] <= zero_i;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0]        trial;
    logic [L-1:0][DW-1:0] rem_d;
    logic [L-1:0][XW-1:0] quo_d;

    assign trial = DW'(n3_q[s]) << (NS - 1 - s);

    always_comb begin
      for (int l = 0; l < L; l++) begin
        quo_d[l] = quo_q[s][l];
        if (rem_q[s][l] >= trial) begin
          rem_d[l] = rem_q[s][l] - trial;
          quo_d[l][NS-1-s] = 1'b1;
        end else begin
          rem_d[l] = rem_q[s][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        quo_q[s+1]  <= quo_d;
        n3_q[s+1]   <= n3_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  pnj_pkg::entry_vec_t ent_d;
  logic                sat_d;

  always_comb begin
    logic [XW-1:0] lim;
    logic [QW-1:0] mag;
    sat_d = 1'b0;
    for (int l = 0; l < L; l++) begin
      lim = neg_q[NS][l] ? (XW'(1) << (QW - 1)) : ((XW'(1) << (QW - 1)) - XW'(1));
      if (quo_q[NS][l] > lim) begin
        mag   = lim[QW-1:0];
        sat_d = 1'b1;
      end else begin
        mag = quo_q[NS][l][QW-1:0];
      end
      ent_d[l] = neg_q[NS][l] ? QW'(-mag) : mag;
    end
    if (zero_q[NS]) begin
      ent_d = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_o <= ent_d;
      sat_o   <= sat_d;
      zero_o  <= zero_q[NS];
    end
  end

endmodule

// ===== rtl/point_normalization_jacobian_unit.sv =====
// Top level of the point normalization Jacobian unit.
// Instantiates pnj_front and pnj_div; uses pnj_pkg.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    x_coord_i y_coord_i z_coord_i norm_i
//   out      out_valid_o / out_ready_i  j_xx_o .. j_yz_o sat_flag_o zero_norm_o
//
// One item per cycle unless the output stalls. Four front stages, the
// divider input register, one divider stage per quotient bit, saturation
// into the output register. The whole pipeline advances as one; a stalled
// output holds every stage. Reset clears only the valid bits.
module point_normalization_jacobian_unit #(
  parameter int unsigned FRAC_BITS = pnj_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pnj_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [pnj_pkg::COORD_W-1:0]  y_coord_i,
  input  logic signed [pnj_pkg::COORD_W-1:0]  z_coord_i,
  input  logic        [pnj_pkg::NORM_W-1:0]   norm_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pnj_pkg::Q_W-1:0]      j_xx_o,
  output logic signed [pnj_pkg::Q_W-1:0]      j_yy_o,
  output logic signed [pnj_pkg::Q_W-1:0]      j_zz_o,
  output logic signed [pnj_pkg::Q_W-1:0]      j_xy_o,
  output logic signed [pnj_pkg::Q_W-1:0]      j_xz_o,
  output logic signed [pnj_pkg::Q_W-1:0]      j_yz_o,
  output logic                                sat_flag_o,
  output logic                                zero_norm_o
);

  logic                        en;
  logic                        f_valid;
  pnj_pkg::prod_vec_t          f_prod;
  logic [pnj_pkg::N3_W-1:0]    f_n3;
  logic [pnj_pkg::LANES-1:0]   f_neg;
  logic                        f_zero;
  pnj_pkg::entry_vec_t         ent;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  pnj_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .z_coord_i (z_coord_i),
    .norm_i    (norm_i),
    .valid_o   (f_valid),
    .prod_o    (f_prod),
    .n3_o      (f_n3),
    .neg_o     (f_neg),
    .zero_o    (f_zero)
  );

  pnj_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .prod_i  (f_prod),
    .n3_i    (f_n3),
    .neg_i   (f_neg),
    .zero_i  (f_zero),
    .valid_o (out_valid_o),
    .entry_o (ent),
    .sat_o   (sat_flag_o),
    .zero_o  (zero_norm_o)
  );

  assign j_xx_o = ent[pnj_pkg::LANE_XX];
  assign j_yy_o = ent[pnj_pkg::LANE_YY];
  assign j_zz_o = ent[pnj_pkg::LANE_ZZ];
  assign j_xy_o = ent[pnj_pkg::LANE_XY];
  assign j_xz_o = ent[pnj_pkg::LANE_XZ];
  assign j_yz_o = ent[pnj_pkg::LANE_YZ];

endmodule

// ===== tb/tb_top.sv =====
// Testbench for point_normalization_jacobian_unit: drives points and norms
// over a valid/ready channel and checks every Jacobian against an internal
// fixed-point predictor. Depends on pnj_pkg and the unit's RTL.
module tb_top;

  typedef struct packed {
    logic [pnj_pkg::COORD_W-1:0] x;
    logic [pnj_pkg::COORD_W-1:0] y;
    logic [pnj_pkg::COORD_W-1:0] z;
    logic [pnj_pkg::NORM_W-1:0]  n;
  } point_t;

  typedef struct packed {
    logic [pnj_pkg::Q_W-1:0] xx;
    logic [pnj_pkg::Q_W-1:0] yy;
    logic [pnj_pkg::Q_W-1:0] zz;
    logic [pnj_pkg::Q_W-1:0] xy;
    logic [pnj_pkg::Q_W-1:0] xz;
    logic [pnj_pkg::Q_W-1:0] yz;
    logic                    sat;
    logic                    zn;
  } jacobian_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [pnj_pkg::COORD_W-1:0] x_coord_i = '0;
  logic signed [pnj_pkg::COORD_W-1:0] y_coord_i = '0;
  logic signed [pnj_pkg::COORD_W-1:0] z_coord_i = '0;
  logic [pnj_pkg::NORM_W-1:0] norm_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [pnj_pkg::Q_W-1:0] j_xx_o, j_yy_o, j_zz_o, j_xy_o, j_xz_o, j_yz_o;
  logic sat_flag_o, zero_norm_o;

  jacobian_t jac_pending[$];
  int mismatches = 0;
  int results_seen = 0;
  int out_hold = 0;
  bit stim_done = 1'b0;

  point_normalization_jacobian_unit dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [pnj_pkg::Q_W-1:0] jac_entry(logic [pnj_pkg::PROD_W:0] p, bit neg,
                                                        logic [pnj_pkg::NORM_W-1:0] n,
                                                        ref bit sat);
    logic [255:0] num, den, q, lim;
    num = {191'd0, p} << (2 * pnj_pkg::FRAC_BITS_DEF);
    den = {225'd0, n} * {225'd0, n} * {225'd0, n};
    q = num / den;
    lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  function automatic jacobian_t predict_jacobian(point_t pt);
    jacobian_t r;
    logic [pnj_pkg::PROD_W:0] ax, ay, az;
    bit sx, sy, sz, sat;
    sat = 1'b0;
    r = '0;
    sx = pt.x[31];
    sy = pt.y[31];
    sz = pt.z[31];
    ax = sx ? 65'(-$signed({1'b1, pt.x})) : 65'(pt.x);
    ay = sy ? 65'(-$signed({1'b1, pt.y})) : 65'(pt.y);
    az = sz ? 65'(-$signed({1'b1, pt.z})) : 65'(pt.z);
    if (pt.n == '0) begin
      r.zn = 1'b1;
      return r;
    end
    r.xx = jac_entry(ay * ay + az * az, 1'b0, pt.n, sat);
    r.yy = jac_entry(ax * ax + az * az, 1'b0, pt.n, sat);
    r.zz = jac_entry(ax * ax + ay * ay, 1'b0, pt.n, sat);
    r.xy = jac_entry(ax * ay, (sx == sy) && (ax * ay != 0), pt.n, sat);
    r.xz = jac_entry(ax * az, (sx == sz) && (ax * az != 0), pt.n, sat);
    r.yz = jac_entry(ay * az, (sy == sz) && (ay * az != 0), pt.n, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(3) == 0) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(40, 10);
    return $urandom_range(3);
  endfunction

  task automatic send_point(point_t pt);
    int gap;
    gap = ($urandom_range(2) == 0) ? rand_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    jac_pending.push_back(predict_jacobian(pt));
    in_valid_i <= 1'b1;
    x_coord_i <= pt.x;
    y_coord_i <= pt.y;
    z_coord_i <= pt.z;
    norm_i <= pt.n;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(200000)) - 100000) * 32'd7;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    pt.x = rand_coord();
    pt.y = rand_coord();
    pt.z = rand_coord();
    case ($urandom_range(5))
      0: pt.n = pnj_pkg::NORM_W'($urandom);
      1: pt.n = pnj_pkg::NORM_W'($urandom_range(255));
      2: pt.n = '0;
      default: pt.n = pnj_pkg::NORM_W'($urandom_range(32'h0400_0000, 32'h0001_0000));
    endcase
    return pt;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (jac_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_point('{32'h0001_0000, 32'd0, 32'd0, 31'h0001_0000});
    send_point('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0001_bb68});
    send_point('{32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 31'h0001_bb68});
    send_point('{32'h1234_5678, 32'h8765_4321, 32'h0, 31'd0});
    send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd1});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 31'h7FFF_FFFF});
    send_point('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 31'd1});
    send_point('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 31'h5555_5555});
    send_point('{32'h0, 32'h0, 32'h0, 31'h0001_0000});
    send_point('{32'h0, 32'h0, 32'h0, 31'd0});
    send_point('{32'h0000_0100, 32'h0, 32'h0, 31'd1});
    send_point('{32'hFFFF_FF00, 32'h0000_0100, 32'h0, 31'd1});
    send_point('{32'h0003_0000, 32'hFFFC_0000, 32'h0, 31'h0005_0000});
    send_point('{32'h0003_0000, 32'h0004_0000, 32'h000C_0000, 31'h000D_0000});
    send_point('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA});
  endtask

  task automatic test_random(int count);
    repeat (count) send_point(rand_point());
  endtask

  task automatic test_drain_pause();
    test_random(20);
    wait_drained();
    test_random(20);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stim_done && jac_pending.size() == 0) begin
        out_ready_i <= 1'b1;
      end else if (out_hold > 0) begin
        out_hold--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(4) == 0) begin
        out_hold = rand_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    jacobian_t got, exp_j;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{j_xx_o, j_yy_o, j_zz_o, j_xy_o, j_xz_o, j_yz_o, sat_flag_o, zero_norm_o};
      results_seen++;
      if (jac_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_j = jac_pending.pop_front();
        if (got !== exp_j) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_j, got);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(990);
    stim_done = 1'b1;
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && jac_pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
